FILE: sv/ogc_pkg.sv
// Shared constants, types and saturation helper for the ADC offset/gain calibrator.
package ogc_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CHAN_W       = 2;
    localparam int CMD_W        = 2;
    localparam int SAMPLE_W     = 24;
    localparam int DMAG_W       = 24;
    localparam int VOLT_W       = 30;
    localparam int PROD_W       = DMAG_W + VOLT_W;
    localparam int FSR_W        = 32;
    localparam int UV_W         = 32;
    localparam int DIV_W        = 32;
    localparam int CFG_IDX_W    = 4;

    localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFFSET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GAIN    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FS_BASE  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_BASE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_REGS = 4'd8;

    localparam logic signed [SAMPLE_W-1:0] POS_FULL_SCALE = SAMPLE_W'(8388607);
    localparam logic signed [SAMPLE_W-1:0] NEG_FULL_SCALE = SAMPLE_W'(-8388608);

    localparam logic [VOLT_W-1:0] RESET_VOLTAGE    = VOLT_W'(30000000);
    localparam logic [FSR_W-1:0]  RESET_FS_READING = FSR_W'(32'h007f_ffff);

    localparam logic [UV_W-1:0] UV_MAX = {1'b0, {(UV_W-1){1'b1}}};
    localparam logic [UV_W-1:0] UV_MIN = {1'b1, {(UV_W-1){1'b0}}};

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    function automatic logic [UV_W-1:0] sat_mag(input logic [PROD_W-1:0] mag,
                                                 input logic neg);
        logic [UV_W-1:0] res;
        if (neg) begin
            if (mag > PROD_W'(UV_MIN)) res = UV_MIN;
            else                       res = -mag[UV_W-1:0];
        end else begin
            if (mag > PROD_W'(UV_MAX)) res = UV_MAX;
            else                       res = mag[UV_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/ogc_if.sv
// Valid/ready channel interfaces for calibrator samples and results.
interface ogc_in_if;
    import ogc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output cmd, output chan, output sample, input ready);
    modport sink   (input valid, input cmd, input chan, input sample, output ready);
endinterface

interface ogc_out_if;
    import ogc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CHAN_W-1:0]      out_chan;
    logic signed [UV_W-1:0] microvolts;
    logic                   over_range;
    logic                   under_range;
    logic                   div_fault;

    modport source (output valid, output out_chan, output microvolts, output over_range,
                    output under_range, output div_fault, input ready);
    modport sink   (input valid, input out_chan, input microvolts, input over_range,
                    input under_range, input div_fault, output ready);
endinterface

FILE: sv/ogc_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module ogc_mul import ogc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DMAG_W-1:0] i_mcand,
    input  logic [VOLT_W-1:0] i_mplier,
    output t_unit_stat        o_stat,
    output logic [PROD_W-1:0] o_prod
);

    localparam int MUL_CNT_W = $clog2(VOLT_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [DMAG_W-1:0]    r_mcand;
    logic [PROD_W-1:0]    r_prod;
    logic [DMAG_W:0]      sum;
    logic [PROD_W-1:0]    n_prod;

    assign sum    = {1'b0, r_prod[PROD_W-1:VOLT_W]}
                  + (r_prod[0] ? {1'b0, r_mcand} : {(DMAG_W+1){1'b0}});
    assign n_prod = {sum, r_prod[VOLT_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(VOLT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_prod  <= {{DMAG_W{1'b0}}, i_mplier};
        end else if (r_busy) begin
            r_prod <= n_prod;
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_prod = r_prod;

endmodule

FILE: sv/ogc_div.sv
// Restoring radix-2 divider: one quotient bit per cycle.
module ogc_div import ogc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_rem_init,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output t_unit_stat       o_stat,
    output logic [DIV_W-1:0] o_quot
);

    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_dq;
    logic [DIV_W-1:0]     r_div;
    logic [DIV_W:0]       sh;
    logic [DIV_W:0]       diff;
    logic                 ge;

    assign sh   = {r_rem, r_dq[DIV_W-1]};
    assign ge   = sh >= {1'b0, r_div};
    assign diff = sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_dq  <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
            r_dq  <= {r_dq[DIV_W-2:0], ge};
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done};
    assign o_quot = r_dq;

endmodule

FILE: sv/adc_offset_gain_calibrator_top.sv
// Four-channel ADC two-point offset/gain calibrator, bit-serial datapath.
// Sequence, accept to result valid: measure or offset capture runs prep, serial multiply,
// serial divide and load; gain capture first adds a serial divide and a serial multiply;
// the final divide is skipped when its divisor is zero or its quotient would overflow.
// No beat is accepted until the last has loaded; a waiting result holds only the next load.
// Synchronous active-low reset restores register, offset and full-scale defaults.
module adc_offset_gain_calibrator_top import ogc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VOLT_W-1:0]    i_cfg_data,
    ogc_in_if.sink               i_sample_ch,
    ogc_out_if.source            o_result_ch
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_DIVQ = 7'b0000100,
        S_MULG = 7'b0001000,
        S_MULM = 7'b0010000,
        S_DIVM = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [VOLT_W-1:0]          r_fs  [NUM_CHANNELS];
    logic [VOLT_W-1:0]          r_ref [NUM_CHANNELS];
    logic [SAMPLE_W-1:0]        r_off [NUM_CHANNELS];
    logic [FSR_W-1:0]           r_fsr [NUM_CHANNELS];

    logic [CMD_W-1:0]           r_cmd;
    logic [CHAN_W-1:0]          r_chan;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [DMAG_W-1:0]          r_dmag;
    logic                       r_dneg;
    logic [UV_W-1:0]            r_uv;
    logic                       r_fault;
    logic                       r_mul_start;
    logic                       r_div_start;

    logic                       r_out_valid;
    logic [CHAN_W-1:0]          r_out_chan;
    logic [UV_W-1:0]            r_out_uv;
    logic                       r_out_over;
    logic                       r_out_under;
    logic                       r_out_fault;

    t_unit_stat                 mul_stat;
    t_unit_stat                 div_stat;
    logic [PROD_W-1:0]          mul_prod;
    logic [DIV_W-1:0]           div_quot;

    logic                       in_acc;
    logic                       out_load;
    logic                       in_chan_ok;
    logic                       chan_ok;
    logic [VOLT_W-1:0]          fs_sel;
    logic [VOLT_W-1:0]          ref_sel;
    logic [FSR_W-1:0]           fsr_sel;
    logic [SAMPLE_W-1:0]        off_sel;
    logic [FSR_W-1:0]           fsr_abs;
    logic                       qneg;
    logic [VOLT_W-1:0]          q_sel;
    logic [VOLT_W-1:0]          mul_mplier;
    logic [PROD_W-DIV_W-1:0]    num_hi;
    logic                       div_ovf;
    logic [DIV_W-1:0]           div_rem_init;
    logic [DIV_W-1:0]           div_dividend;
    logic [DIV_W-1:0]           div_divisor;
    logic [SAMPLE_W:0]          d_full;
    logic                       n_mul_start;
    logic                       n_div_start;

    assign in_acc     = i_sample_ch.valid && i_sample_ch.ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || o_result_ch.ready);
    assign in_chan_ok = {1'b0, i_sample_ch.chan} < (CHAN_W+1)'(NUM_CHANNELS);
    assign chan_ok    = {1'b0, r_chan} < (CHAN_W+1)'(NUM_CHANNELS);

    assign fs_sel  = r_fs[r_chan];
    assign ref_sel = r_ref[r_chan];
    assign fsr_sel = r_fsr[r_chan];
    assign off_sel = r_off[r_chan];
    assign fsr_abs = fsr_sel[FSR_W-1] ? -fsr_sel : fsr_sel;
    assign qneg    = r_dneg ^ fsr_sel[FSR_W-1];
    assign d_full  = {r_sample[SAMPLE_W-1], r_sample} - {off_sel[SAMPLE_W-1], off_sel};

    assign q_sel      = (ref_sel == '0) ? '0 : div_quot[VOLT_W-1:0];
    assign mul_mplier = (r_state == S_MULG) ? q_sel : fs_sel;

    assign num_hi       = mul_prod[PROD_W-1:DIV_W];
    assign div_ovf      = DIV_W'(num_hi) >= fsr_abs;
    assign div_rem_init = (r_state == S_DIVQ) ? '0 : DIV_W'(num_hi);
    assign div_dividend = (r_state == S_DIVQ) ? DIV_W'(fs_sel) : mul_prod[DIV_W-1:0];
    assign div_divisor  = (r_state == S_DIVQ) ? DIV_W'(ref_sel) : fsr_abs;

    ogc_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_start),
        .i_mcand  (r_dmag),
        .i_mplier (mul_mplier),
        .o_stat   (mul_stat),
        .o_prod   (mul_prod)
    );

    ogc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_rem_init (div_rem_init),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_mul_start = 1'b0;
        n_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_PREP;
            end
            S_PREP: begin
                if (!chan_ok) begin
                    n_state = S_DONE;
                end else if (r_cmd == CMD_GAIN) begin
                    n_state     = S_DIVQ;
                    n_div_start = 1'b1;
                end else begin
                    n_state     = S_MULM;
                    n_mul_start = 1'b1;
                end
            end
            S_DIVQ: begin
                if (div_stat.done) begin
                    n_state     = S_MULG;
                    n_mul_start = 1'b1;
                end
            end
            S_MULG: begin
                if (mul_stat.done) begin
                    n_state     = S_MULM;
                    n_mul_start = 1'b1;
                end
            end
            S_MULM: begin
                if (mul_stat.done) begin
                    if (fsr_sel == '0 || div_ovf) begin
                        n_state = S_DONE;
                    end else begin
                        n_state     = S_DIVM;
                        n_div_start = 1'b1;
                    end
                end
            end
            S_DIVM: begin
                if (div_stat.done) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mul_start <= n_mul_start;
            r_div_start <= n_div_start;
            if (out_load)                r_out_valid <= 1'b1;
            else if (o_result_ch.ready)  r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_fs[i]  <= RESET_VOLTAGE;
                r_ref[i] <= RESET_VOLTAGE;
                r_off[i] <= '0;
                r_fsr[i] <= RESET_FS_READING;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_REF_BASE) begin
                    r_fs[i_cfg_idx[CHAN_W-1:0]] <= i_cfg_data;
                end else if (i_cfg_idx < CFG_NUM_REGS) begin
                    r_ref[i_cfg_idx[CHAN_W-1:0]] <= i_cfg_data;
                end
            end
            if (in_acc && in_chan_ok && i_sample_ch.cmd == CMD_OFFSET) begin
                r_off[i_sample_ch.chan] <= i_sample_ch.sample;
            end
            if (r_state == S_MULG && mul_stat.done) begin
                r_fsr[r_chan] <= sat_mag(mul_prod, r_dneg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd    <= i_sample_ch.cmd;
            r_chan   <= i_sample_ch.chan;
            r_sample <= i_sample_ch.sample;
        end
        if (r_state == S_PREP) begin
            r_dneg  <= d_full[SAMPLE_W];
            r_dmag  <= d_full[SAMPLE_W] ? DMAG_W'(-d_full) : d_full[DMAG_W-1:0];
            r_uv    <= '0;
            r_fault <= 1'b0;
        end
        if (r_state == S_MULM && mul_stat.done) begin
            if (fsr_sel == '0) begin
                r_fault <= 1'b1;
            end else if (div_ovf) begin
                r_uv <= qneg ? UV_MIN : UV_MAX;
            end
        end
        if (r_state == S_DIVM && div_stat.done) begin
            r_uv <= sat_mag(PROD_W'(div_quot), qneg);
        end
        if (out_load) begin
            r_out_chan  <= r_chan;
            r_out_uv    <= r_uv;
            r_out_over  <= r_sample >= POS_FULL_SCALE;
            r_out_under <= r_sample <= NEG_FULL_SCALE;
            r_out_fault <= r_fault;
        end
    end

    assign i_sample_ch.ready       = (r_state == S_IDLE);
    assign o_result_ch.valid       = r_out_valid;
    assign o_result_ch.out_chan    = r_out_chan;
    assign o_result_ch.microvolts  = r_out_uv;
    assign o_result_ch.over_range  = r_out_over;
    assign o_result_ch.under_range = r_out_under;
    assign o_result_ch.div_fault   = r_out_fault;

`ifndef ASSERT_OFF
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fault) |-> (r_out_uv == '0))
        else $error("division fault with nonzero result");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("loaded result not presented");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking bench for the four-channel offset/gain calibrator: predicted vs. DUT results.
module testbench;
    import ogc_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [VOLT_W-1:0] VOLT_MAX   = '1;
    localparam int                REPORT_CAP = 40;

    typedef struct packed {
        logic [CMD_W-1:0]           cmd;
        logic [CHAN_W-1:0]          chan;
        logic signed [SAMPLE_W-1:0] sample;
    } t_conv_beat;

    typedef struct packed {
        logic [CHAN_W-1:0]      chan;
        logic signed [UV_W-1:0] uv;
        logic                   ovr;
        logic                   und;
        logic                   flt;
    } t_reading;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [VOLT_W-1:0]    i_cfg_data = '0;

    ogc_in_if  smp_if ();
    ogc_out_if res_if ();

    adc_offset_gain_calibrator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample_ch (smp_if.sink),
        .o_result_ch (res_if.source)
    );

    // calibration state mirrored from the block
    logic signed [SAMPLE_W-1:0] offs   [NUM_CHANNELS];
    logic signed [FSR_W-1:0]    fsr    [NUM_CHANNELS];
    logic [VOLT_W-1:0]          fs_uv  [NUM_CHANNELS];
    logic [VOLT_W-1:0]          ref_uv [NUM_CHANNELS];

    t_conv_beat samples_to_send [$];
    t_reading   readings_due    [$];

    int n_queued, n_sent, n_checked, n_cfg_writes, n_faults, n_sats, n_errors;
    int burst_left, gap_left;
    t_conv_beat nxt;
    t_reading   want;
    logic [15:0] stall_pat = '1;
    logic [3:0]  pat_pos   = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [UV_W-1:0] clamp_i32(input longint v);
        if (v > 64'sd2147483647) begin
            n_sats++;
            return UV_MAX;
        end
        if (v < -64'sd2147483648) begin
            n_sats++;
            return UV_MIN;
        end
        return v[UV_W-1:0];
    endfunction

    function automatic t_reading calibrated_reading(input logic [CMD_W-1:0] cmd,
                                                    input logic [CHAN_W-1:0] ch,
                                                    input logic signed [SAMPLE_W-1:0] smp);
        t_reading r;
        longint   diff;
        logic [VOLT_W-1:0] q;
        r.chan = ch;
        r.uv   = '0;
        r.flt  = 1'b0;
        r.ovr  = (smp >= POS_FULL_SCALE);
        r.und  = (smp <= NEG_FULL_SCALE);
        if (cmd == CMD_OFFSET) begin
            offs[ch] = smp;
        end else if (cmd == CMD_GAIN) begin
            q = (ref_uv[ch] != '0) ? fs_uv[ch] / ref_uv[ch] : '0;
            diff = longint'(smp) - longint'(offs[ch]);
            fsr[ch] = clamp_i32(diff * longint'(q));
        end
        if (fsr[ch] == '0) begin
            r.flt = 1'b1;
            n_faults++;
        end else begin
            diff = longint'(smp) - longint'(offs[ch]);
            r.uv = clamp_i32((diff * longint'(fs_uv[ch])) / longint'(fsr[ch]));
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= REPORT_CAP) $display("ERROR t=%0t: %s", $time, msg);
    endtask

    task automatic queue_beat(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] ch,
                              input logic signed [SAMPLE_W-1:0] smp);
        t_conv_beat b;
        b.cmd    = cmd;
        b.chan   = ch;
        b.sample = smp;
        samples_to_send.push_back(b);
        n_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VOLT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        n_cfg_writes++;
        if (idx >= CFG_REF_BASE && idx < CFG_NUM_REGS) ref_uv[idx - CFG_REF_BASE] = val;
        else if (idx < CFG_REF_BASE) fs_uv[idx - CFG_FS_BASE] = val;
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (samples_to_send.size() != 0 || smp_if.valid || readings_due.size() != 0);
        repeat (16) @(negedge i_clk);
    endtask

    function automatic logic [VOLT_W-1:0] rand_volt();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return VOLT_W'(1);
            2:       return VOLT_MAX;
            3:       return VOLT_W'(1000000000);
            4, 5, 6: return VOLT_W'($urandom_range(1, 1000));
            default: return VOLT_W'($urandom_range(1000000, 1000000000));
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0:       return POS_FULL_SCALE;
            1:       return NEG_FULL_SCALE;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic program_random_setting();
        logic [VOLT_W-1:0] fs;
        logic [VOLT_W-1:0] rv;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            fs = rand_volt();
            rv = ($urandom_range(0, 3) == 0) ? rand_volt() : fs / VOLT_W'($urandom_range(1, 4));
            write_reg(CFG_FS_BASE + CFG_IDX_W'(ch), fs);
            write_reg(CFG_REF_BASE + CFG_IDX_W'(ch), rv);
        end
        write_reg(CFG_NUM_REGS + CFG_IDX_W'($urandom_range(0, 7)), VOLT_W'($urandom));
        end_writes();
    endtask

    task automatic queue_chunk(input int n);
        int target, reps;
        logic [CHAN_W-1:0] ch;
        target = n_queued + n;
        while (n_queued < target) begin
            ch = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 3) != 0)
                    queue_beat(CMD_OFFSET, ch, SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096));
                if ($urandom_range(0, 3) != 0)
                    queue_beat(CMD_GAIN, ch, ($urandom_range(0, 4) == 0) ? rand_sample()
                                             : SAMPLE_W'($urandom_range(100000, 8388607)));
                reps = $urandom_range(2, 6);
                repeat (reps)
                    queue_beat(($urandom_range(0, 7) == 0) ? CMD_UNUSED : CMD_MEASURE, ch,
                               rand_sample());
            end else begin
                queue_beat(CMD_W'($urandom_range(0, 3)), CHAN_W'($urandom_range(0, 3)),
                           rand_sample());
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid  <= 1'b0;
            smp_if.cmd    <= CMD_MEASURE;
            smp_if.chan   <= '0;
            smp_if.sample <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (smp_if.valid && smp_if.ready) begin
                readings_due.push_back(calibrated_reading(smp_if.cmd, smp_if.chan,
                                                          smp_if.sample));
                n_sent++;
            end
            if (!smp_if.valid || smp_if.ready) begin
                if (gap_left > 0) begin
                    smp_if.valid <= 1'b0;
                    gap_left--;
                end else if (samples_to_send.size() != 0) begin
                    nxt = samples_to_send.pop_front();
                    smp_if.valid  <= 1'b1;
                    smp_if.cmd    <= nxt.cmd;
                    smp_if.chan   <= nxt.chan;
                    smp_if.sample <= nxt.sample;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                n_checked++;
                if (readings_due.size() == 0) begin
                    report_mismatch("result beat with no reading pending");
                end else begin
                    want = readings_due.pop_front();
                    if (res_if.out_chan !== want.chan)
                        report_mismatch($sformatf("result %0d: out_chan %0d, want %0d",
                                                  n_checked, res_if.out_chan, want.chan));
                    if (res_if.microvolts !== want.uv)
                        report_mismatch($sformatf("result %0d: microvolts %0d, want %0d",
                                                  n_checked, res_if.microvolts, want.uv));
                    if (res_if.over_range !== want.ovr)
                        report_mismatch($sformatf("result %0d: over_range %b, want %b",
                                                  n_checked, res_if.over_range, want.ovr));
                    if (res_if.under_range !== want.und)
                        report_mismatch($sformatf("result %0d: under_range %b, want %b",
                                                  n_checked, res_if.under_range, want.und));
                    if (res_if.div_fault !== want.flt)
                        report_mismatch($sformatf("result %0d: div_fault %b, want %b",
                                                  n_checked, res_if.div_fault, want.flt));
                end
            end
            res_if.ready <= stall_pat[pat_pos];
            if (pat_pos == 4'hf) begin
                case ($urandom_range(0, 3))
                    0:       stall_pat = '1;
                    1:       stall_pat = 16'($urandom) & 16'($urandom);
                    default: stall_pat = 16'($urandom) | 16'($urandom);
                endcase
            end
            pat_pos = pat_pos + 4'd1;
        end
    end

    initial begin
        #15000000;
        $display("timeout: %0d readings still pending", readings_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            offs[ch]   = '0;
            fsr[ch]    = RESET_FS_READING;
            fs_uv[ch]  = RESET_VOLTAGE;
            ref_uv[ch] = RESET_VOLTAGE;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: flags, unused code, offset, gain, zero reading, saturation
        queue_beat(CMD_MEASURE, 2'd0, '0);
        queue_beat(CMD_MEASURE, 2'd1, POS_FULL_SCALE);
        queue_beat(CMD_MEASURE, 2'd2, NEG_FULL_SCALE);
        queue_beat(CMD_UNUSED,  2'd3, '1);
        queue_beat(CMD_OFFSET,  2'd0, 24'sd100);
        queue_beat(CMD_MEASURE, 2'd0, 24'sd100);
        queue_beat(CMD_MEASURE, 2'd0, NEG_FULL_SCALE);
        queue_beat(CMD_GAIN,    2'd0, 24'sd5000000);
        queue_beat(CMD_GAIN,    2'd1, '0);
        queue_beat(CMD_MEASURE, 2'd1, 24'sd123);
        queue_beat(CMD_OFFSET,  2'd2, POS_FULL_SCALE);
        queue_beat(CMD_GAIN,    2'd2, NEG_FULL_SCALE);
        queue_beat(CMD_MEASURE, 2'd2, POS_FULL_SCALE);
        queue_beat(CMD_MEASURE, 2'd2, NEG_FULL_SCALE);
        queue_beat(CMD_OFFSET,  2'd3, NEG_FULL_SCALE);
        queue_beat(CMD_MEASURE, 2'd3, POS_FULL_SCALE);
        queue_beat(CMD_GAIN,    2'd3, -24'sd8388607);
        queue_beat(CMD_MEASURE, 2'd3, POS_FULL_SCALE);
        queue_beat(CMD_OFFSET,  2'd3, POS_FULL_SCALE);
        queue_beat(CMD_MEASURE, 2'd3, NEG_FULL_SCALE);
        wait_idle();

        // extreme registers: huge quotient, zero full scale, zero reference, stray index
        write_reg(CFG_FS_BASE,  VOLT_MAX);
        write_reg(CFG_REF_BASE, VOLT_W'(1));
        write_reg(CFG_FS_BASE + CFG_IDX_W'(2), '0);
        write_reg(CFG_REF_BASE + CFG_IDX_W'(3), '0);
        write_reg(CFG_NUM_REGS, VOLT_MAX);
        write_reg(CFG_NUM_REGS + CFG_IDX_W'(7), '0);
        end_writes();
        queue_beat(CMD_GAIN,    2'd0, POS_FULL_SCALE);
        queue_beat(CMD_GAIN,    2'd0, NEG_FULL_SCALE);
        queue_beat(CMD_MEASURE, 2'd0, 24'sd5);
        queue_beat(CMD_MEASURE, 2'd2, 24'sd77);
        queue_beat(CMD_GAIN,    2'd3, 24'sd1000);
        queue_beat(CMD_MEASURE, 2'd3, 24'sd9);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            program_random_setting();
            for (int ck = 0; ck < 4; ck++) begin
                queue_chunk(54);
                if ($urandom_range(0, 1) == 0) wait_idle();
            end
            wait_idle();
        end

        repeat (200) @(posedge i_clk);
        if (readings_due.size() != 0)
            report_mismatch($sformatf("%0d readings never arrived", readings_due.size()));
        $display("sent %0d beats across %0d register writes, checked %0d results",
                 n_sent, n_cfg_writes, n_checked);
        $display("predicted %0d division faults and %0d saturations, %0d mismatches",
                 n_faults, n_sats, n_errors);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
